FILE: hdl/bary_ccw_angle_compare_macros.svh
// Assertion macros shared by the checker of the angle comparator.
// Plain text only; no dependencies.
`ifndef BARY_CCW_ANGLE_COMPARE_MACROS_SVH
`define BARY_CCW_ANGLE_COMPARE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high
`define BACC_CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high
`define BACC_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/bacc_pkg.sv
// Shared types and constants of the barycentric angle comparator.
// Used by bacc_mul and bary_ccw_angle_compare; no dependencies.
package bacc_pkg;

  // Default width of one barycentric weight
  localparam int COORD_BITS_DEF = 24;

  // Limb width of the split multipliers
  localparam int LIMB_BITS = 32;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_A = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_B = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_C = 2'd2;

  // Quadrant after folding; numeric order is the sort order
  typedef enum logic [1:0] {
    QUAD_1 = 2'd0,
    QUAD_2 = 2'd1,
    QUAD_3 = 2'd2,
    QUAD_4 = 2'd3
  } quad_t;

  // Load enables of the three multiplier stages
  typedef struct packed {
    logic pp;
    logic row;
    logic sum;
  } mul_en_t;

endpackage

FILE: hdl/bacc_mul.sv
// Three-stage unsigned multiplier built from limb-sized partial products.
// Uses bacc_pkg (mul_en_t, LIMB_BITS).
module bacc_mul #(
  parameter int AW = 50,
  parameter int BW = 50,
  parameter int LW = bacc_pkg::LIMB_BITS
) (
  input  logic                clk,
  input  bacc_pkg::mul_en_t   en,
  input  logic [AW-1:0]       a,
  input  logic [BW-1:0]       b,
  output logic [AW+BW-1:0]    p
);
  localparam int NA  = (AW + LW - 1) / LW;
  localparam int NB  = (BW + LW - 1) / LW;
  localparam int APW = NA * LW;
  localparam int BPW = NB * LW;
  localparam int RW  = BW + LW;
  localparam int PW  = AW + BW;

  logic [APW-1:0]  a_pad;
  logic [BPW-1:0]  b_pad;
  logic [2*LW-1:0] pp [NA][NB];
  logic [RW-1:0]   row [NA];
  logic [RW-1:0]   row_next [NA];
  logic [PW-1:0]   sum_next;

  assign a_pad = APW'(a);
  assign b_pad = BPW'(b);

  // Row sums: one limb of a times all of b
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_next[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_next[i] = row_next[i] + (RW'(pp[i][j]) << (j * LW));
      end
    end
  end

  // Final sum of the shifted rows
  always_comb begin
    sum_next = '0;
    for (int i = 0; i < NA; i++) begin
      sum_next = sum_next + (PW'(row[i]) << (i * LW));
    end
  end

  // Stage registers
  always_ff @(posedge clk) begin
    if (en.pp) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= (2*LW)'(a_pad[i*LW +: LW]) * (2*LW)'(b_pad[j*LW +: LW]);
        end
      end
    end
    if (en.row) begin
      row <= row_next;
    end
    if (en.sum) begin
      p <= sum_next;
    end
  end

endmodule

FILE: hdl/bary_ccw_angle_compare.sv
// Counter-clockwise angle comparator for barycentric points. One beat carries a left and a
// right point; the block answers whether the left one comes strictly first around the center
// held in the center_a/b/c registers (reset 0, 0, 1). A new beat is taken every cycle while
// in_stall is low. The pipe has 11 register stages, the first loaded at the accepting edge:
// one stage forms the weight sums, one the 2x2 products, one the fold into a quadrant, three
// the squares and slope cross products, one the slope and quadrant decision, three the
// distance cross products and one the final compare.
// The wide products run through multipliers split into 32-bit limbs, each taking three of
// those stages. Every stage holds a valid bit and fills holes, so in_stall only rises when all
// 11 stages are full and out_stall is high. Write the center only while no beat is in flight.
module bary_ccw_angle_compare #(
  parameter int COORD_BITS = bacc_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_we,
  input  logic [bacc_pkg::CFG_IDX_BITS-1:0]   cfg_addr,
  input  logic [COORD_BITS-1:0]               cfg_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [COORD_BITS-1:0]        left_a,
  input  logic signed [COORD_BITS-1:0]        left_b,
  input  logic signed [COORD_BITS-1:0]        left_c,
  input  logic signed [COORD_BITS-1:0]        right_a,
  input  logic signed [COORD_BITS-1:0]        right_b,
  input  logic signed [COORD_BITS-1:0]        right_c,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                left_before_right
);
  import bacc_pkg::*;

  localparam int N     = COORD_BITS;
  localparam int SW    = N + 2;        // weight sum
  localparam int PW1   = 2 * N + 2;    // weight times sum
  localparam int UW    = 2 * N + 3;    // u, w
  localparam int DW    = 2 * N + 4;    // d
  localparam int XW    = 2 * N + 2;    // folded x, y and |d|
  localparam int SQW   = 2 * XW;
  localparam int NW    = SQW + 1;
  localparam int FW    = NW + SQW;
  localparam int NSTG  = 11;

  // center registers
  logic signed [N-1:0] center_a;
  logic signed [N-1:0] center_b;
  logic signed [N-1:0] center_c;
  logic signed [SW-1:0] od;

  // flow control
  logic [NSTG:1]   v;
  logic [NSTG+1:1] rdy;
  mul_en_t         en_a;
  mul_en_t         en_b;

  // side 0 is left, side 1 is right
  logic signed [N-1:0]   in_a [2];
  logic signed [N-1:0]   in_b [2];
  logic signed [N-1:0]   in_c [2];
  logic signed [N-1:0]   s1_a [2];
  logic signed [N-1:0]   s1_b [2];
  logic signed [SW-1:0]  s1_sum [2];
  logic signed [PW1-1:0] s2_ao [2];
  logic signed [PW1-1:0] s2_op [2];
  logic signed [PW1-1:0] s2_bo [2];
  logic signed [PW1-1:0] s2_ob [2];
  logic signed [DW-1:0]  s2_d [2];
  logic [XW-1:0]         s3_x [2];
  logic [XW-1:0]         s3_y [2];
  logic [XW-1:0]         s3_dm [2];
  quad_t                 s3_q [2];
  logic [XW-1:0]         x_next [2];
  logic [XW-1:0]         y_next [2];
  logic [XW-1:0]         dm_next [2];
  quad_t                 q_next [2];
  quad_t                 q4 [2];
  quad_t                 q5 [2];
  quad_t                 q6 [2];
  logic [SQW-1:0]        m_yx [2];
  logic [SQW-1:0]        m_xx [2];
  logic [SQW-1:0]        m_yy [2];
  logic [SQW-1:0]        m_dd [2];
  logic [NW-1:0]         s7_nrm [2];
  logic [SQW-1:0]        s7_dd [2];
  logic [FW-1:0]         fin [2];
  logic [NSTG-1:7]       done;
  logic [NSTG-1:7]       res;
  logic                  done_next;
  logic                  res_next;
  logic                  slope_lt;
  logic                  slope_eq;
  logic                  lbr_next;

  assign in_a[0] = left_a;
  assign in_b[0] = left_b;
  assign in_c[0] = left_c;
  assign in_a[1] = right_a;
  assign in_b[1] = right_b;
  assign in_c[1] = right_c;

  // Configuration writes; unknown index is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      center_a <= '0;
      center_b <= '0;
      center_c <= N'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_CENTER_A: center_a <= cfg_data;
        CFG_CENTER_B: center_b <= cfg_data;
        CFG_CENTER_C: center_c <= cfg_data;
        default: ;
      endcase
    end
  end

  assign od = SW'(center_a) + SW'(center_b) + SW'(center_c);

  // Ready chain: a stage loads when it is empty or the next one moves
  always_comb begin
    rdy[NSTG+1] = !out_stall;
    for (int k = NSTG; k >= 1; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign in_stall  = !rdy[1];
  assign out_valid = v[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) begin
        v[1] <= in_valid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign en_a = '{pp: rdy[4], row: rdy[5], sum: rdy[6]};
  assign en_b = '{pp: rdy[8], row: rdy[9], sum: rdy[10]};

  // Per-side front end: sums, products, fold, squares
  for (genvar s = 0; s < 2; s++) begin : g_side
    logic signed [UW-1:0] u;
    logic signed [UW-1:0] w;
    logic signed [UW-1:0] u_neg;
    logic signed [UW-1:0] w_neg;
    logic signed [DW-1:0] d_abs;

    // stage 1: weight sum
    always_ff @(posedge clk) begin
      if (rdy[1]) begin
        s1_a[s]   <= in_a[s];
        s1_b[s]   <= in_b[s];
        s1_sum[s] <= SW'(in_a[s]) + SW'(in_b[s]) + SW'(in_c[s]);
      end
    end

    // stage 2: weight products
    always_ff @(posedge clk) begin
      if (rdy[2]) begin
        s2_ao[s] <= PW1'(s1_a[s]) * PW1'(od);
        s2_op[s] <= PW1'(center_a) * PW1'(s1_sum[s]);
        s2_bo[s] <= PW1'(s1_b[s]) * PW1'(od);
        s2_ob[s] <= PW1'(center_b) * PW1'(s1_sum[s]);
        s2_d[s]  <= DW'(od) * DW'(s1_sum[s]);
      end
    end

    // stage 3: fold (u, w) into a quadrant with x, y >= 0
    always_comb begin
      u     = UW'(s2_ao[s]) - UW'(s2_op[s]);
      w     = UW'(s2_bo[s]) - UW'(s2_ob[s]);
      u_neg = -u;
      w_neg = -w;
      d_abs = s2_d[s][DW-1] ? -s2_d[s] : s2_d[s];
      dm_next[s] = d_abs[XW-1:0];
      unique case ({u[UW-1], w[UW-1]})
        2'b00: begin
          x_next[s] = u[XW-1:0];
          y_next[s] = w[XW-1:0];
          q_next[s] = QUAD_1;
        end
        2'b10: begin
          x_next[s] = w[XW-1:0];
          y_next[s] = u_neg[XW-1:0];
          q_next[s] = QUAD_2;
        end
        2'b11: begin
          x_next[s] = u_neg[XW-1:0];
          y_next[s] = w_neg[XW-1:0];
          q_next[s] = QUAD_3;
        end
        2'b01: begin
          x_next[s] = w_neg[XW-1:0];
          y_next[s] = u[XW-1:0];
          q_next[s] = QUAD_4;
        end
      endcase
    end

    always_ff @(posedge clk) begin
      if (rdy[3]) begin
        s3_x[s]  <= x_next[s];
        s3_y[s]  <= y_next[s];
        s3_dm[s] <= dm_next[s];
        s3_q[s]  <= q_next[s];
      end
    end

    // stages 4-6: squares and slope cross products
    bacc_mul #(.AW(XW), .BW(XW), .LW(LIMB_BITS)) u_mul_yx (
      .clk(clk), .en(en_a), .a(s3_y[s]), .b(s3_x[1-s]), .p(m_yx[s])
    );
    bacc_mul #(.AW(XW), .BW(XW), .LW(LIMB_BITS)) u_mul_xx (
      .clk(clk), .en(en_a), .a(s3_x[s]), .b(s3_x[s]), .p(m_xx[s])
    );
    bacc_mul #(.AW(XW), .BW(XW), .LW(LIMB_BITS)) u_mul_yy (
      .clk(clk), .en(en_a), .a(s3_y[s]), .b(s3_y[s]), .p(m_yy[s])
    );
    bacc_mul #(.AW(XW), .BW(XW), .LW(LIMB_BITS)) u_mul_dd (
      .clk(clk), .en(en_a), .a(s3_dm[s]), .b(s3_dm[s]), .p(m_dd[s])
    );

    // quadrant rides along the multiplier stages
    always_ff @(posedge clk) begin
      if (rdy[4]) q4[s] <= s3_q[s];
      if (rdy[5]) q5[s] <= q4[s];
      if (rdy[6]) q6[s] <= q5[s];
    end

    // stage 7: squared norm
    always_ff @(posedge clk) begin
      if (rdy[7]) begin
        s7_nrm[s] <= NW'(m_xx[s]) + NW'(m_yy[s]);
        s7_dd[s]  <= m_dd[s];
      end
    end

    // stages 8-10: distance cross products
    bacc_mul #(.AW(NW), .BW(SQW), .LW(LIMB_BITS)) u_mul_fin (
      .clk(clk), .en(en_b), .a(s7_nrm[s]), .b(s7_dd[1-s]), .p(fin[s])
    );
  end

  // Stage 7 decision: quadrant first, then slope
  assign slope_lt = m_yx[0] < m_yx[1];
  assign slope_eq = m_yx[0] == m_yx[1];

  always_comb begin
    priority if (q6[0] != q6[1]) begin
      done_next = 1'b1;
      res_next  = q6[0] < q6[1];
    end else if (!slope_eq) begin
      done_next = 1'b1;
      res_next  = slope_lt;
    end else begin
      done_next = 1'b0;
      res_next  = 1'b0;
    end
  end

  // Decision bits follow the distance multipliers
  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      done[7] <= done_next;
      res[7]  <= res_next;
    end
    for (int k = 8; k <= NSTG - 1; k++) begin
      if (rdy[k]) begin
        done[k] <= done[k-1];
        res[k]  <= res[k-1];
      end
    end
  end

  // Stage 11: distance breaks the tie
  assign lbr_next = done[NSTG-1] ? res[NSTG-1] : (fin[0] < fin[1]);

  always_ff @(posedge clk) begin
    if (rdy[NSTG]) begin
      left_before_right <= lbr_next;
    end
  end

endmodule

FILE: hdl/bacc_checker.sv
// Port-level checks of the angle comparator, bound to the top level.
// Uses bary_ccw_angle_compare_macros.svh.
`include "bary_ccw_angle_compare_macros.svh"

module bacc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic left_before_right
);

  // a stalled result beat stays
  `BACC_CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result beat dropped while stalled")
  `BACC_CHK_NEXT(a_out_stable, out_valid && out_stall, $stable(left_before_right), "stalled result changed")

  // with the output side free the pipeline never pushes back
  `BACC_CHK_NOW(a_flow, !out_stall, !in_stall, "input stalled while output is free")

  // the pipeline comes out of reset empty
  `BACC_CHK_NOW(a_rst_empty, $past(rst), !out_valid, "result beat right after reset")

endmodule

bind bary_ccw_angle_compare bacc_checker u_bacc_checker (.*);
